@@ sv/bbcm_pkg.sv @@
// Package: shared types and codes for the block buffer cache manager.
package bbcm_pkg;

  typedef enum logic [1:0] {
    MODE_GET     = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_IODONE  = 2'd2,
    MODE_DELWRI  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_BUSY      = 3'd1,
    ST_NOFREE    = 3'd2,
    ST_WRITEBACK = 3'd3,
    ST_ACK       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    WAKE_NONE  = 2'd0,
    WAKE_FREED = 2'd1,
    WAKE_READ  = 2'd2,
    WAKE_WRITE = 2'd3
  } wake_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MATCH = 2'd1,
    S_EXEC  = 2'd2,
    S_OUT   = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] device;
    logic [31:0] block_number;
    logic [4:0]  buffer_index;
    logic        io_error;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  granted_index;
    logic        data_valid;
    logic [1:0]  wake_class;
  } out_beat_t;

  typedef struct packed {
    logic load;   // capture input beat
    logic match;  // register tag match
    logic exec;   // apply the update, form result
  } ctl_cmd_t;

endpackage

@@ sv/block_buffer_cache_manager.sv @@
// Top level: buffer cache manager, controller plus datapath.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid / in_ready   | in_data  (bbcm_pkg::in_beat_t)
//  out_    | out | out_valid / out_ready | out_data (bbcm_pkg::out_beat_t)
//
// Each beat runs through capture, registered tag match over all buffers,
// one mark/list update, then the result held until out_ready (output stall).
// The match compare tree and the list relink set the stage split.
// A new beat is taken only after the result beat is accepted.
// rst_n is synchronous: all buffers free, list in index order, no tags.
module block_buffer_cache_manager #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned DEVICE_BITS = 16,
  parameter int unsigned BLOCK_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bbcm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bbcm_pkg::out_beat_t out_data
);

  bbcm_pkg::ctl_cmd_t cmd;

  bbcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bbcm_dp #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .DEVICE_BITS (DEVICE_BITS),
    .BLOCK_BITS  (BLOCK_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // never ready for input while holding a result
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  // accepted beat yields a result after the match and update states
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##3 out_valid) else $error("result latency");
  // status code stays in range
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= bbcm_pkg::ST_ACK)) else $error("bad status");
`endif

endmodule

@@ sv/bbcm_ctrl.sv @@
// Controller: sequences capture, tag match, update and result hand-off.
module bbcm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bbcm_pkg::ctl_cmd_t cmd
);

  bbcm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbcm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bbcm_pkg::S_IDLE:  if (in_valid) state_nxt = bbcm_pkg::S_MATCH;
      bbcm_pkg::S_MATCH: state_nxt = bbcm_pkg::S_EXEC;
      bbcm_pkg::S_EXEC:  state_nxt = bbcm_pkg::S_OUT;
      bbcm_pkg::S_OUT:   if (out_ready) state_nxt = bbcm_pkg::S_IDLE;
      default:           state_nxt = bbcm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == bbcm_pkg::S_IDLE);
    out_valid = (state_r == bbcm_pkg::S_OUT);
    cmd.load  = (state_r == bbcm_pkg::S_IDLE) && in_valid;
    cmd.match = (state_r == bbcm_pkg::S_MATCH);
    cmd.exec  = (state_r == bbcm_pkg::S_EXEC);
  end

endmodule

@@ sv/bbcm_dp.sv @@
// Datapath: tags, marks, free list, match and update logic.
module bbcm_dp #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned DEVICE_BITS = 16,
  parameter int unsigned BLOCK_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bbcm_pkg::ctl_cmd_t  cmd,
  input  bbcm_pkg::in_beat_t  in_data,
  output bbcm_pkg::out_beat_t out_data
);

  localparam int unsigned BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned DW = (DEVICE_BITS < 16) ? DEVICE_BITS : 16;
  localparam int unsigned KW = (BLOCK_BITS < 32) ? BLOCK_BITS : 32;

  logic [DW-1:0] tag_dev_r [NUM_BUFFERS];
  logic [KW-1:0] tag_blk_r [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] present_r, busy_r, valid_r, dirty_r, inlist_r;
  logic [BW-1:0] next_r [NUM_BUFFERS];
  logic [BW-1:0] prev_r [NUM_BUFFERS];
  logic [BW-1:0] head_r;
  logic          empty_r;

  bbcm_pkg::in_beat_t  req_r;
  bbcm_pkg::out_beat_t res_r;
  logic                hit_r;
  logic [BW-1:0]       hit_idx_r;

  assign out_data = res_r;

  // associative match, lowest index wins
  logic [NUM_BUFFERS-1:0] hv;
  logic          hit_c;
  logic [BW-1:0] hidx_c;
  always_comb begin
    hit_c  = 1'b0;
    hidx_c = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      hv[i] = present_r[i] && tag_dev_r[i] == req_r.device[DW-1:0]
              && tag_blk_r[i] == req_r.block_number[KW-1:0];
    end
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (hv[i]) begin
        hit_c  = 1'b1;
        hidx_c = BW'(i);
      end
    end
  end

  logic          rng_ok;
  logic [BW-1:0] ridx;
  assign rng_ok = 32'(req_r.buffer_index) < NUM_BUFFERS;
  assign ridx   = BW'(req_r.buffer_index);

  // at most one list op per beat: remove t, or add t (at head if first)
  logic          do_rm, do_add, add_first;
  logic [BW-1:0] t;
  logic [BW-1:0] t_n, t_p, tail;
  bbcm_pkg::out_beat_t res_c;
  logic          set_busy, clr_busy, retag, set_valid, valid_val;
  logic          set_dirty, clr_dirty;

  always_comb begin
    do_rm = 1'b0; do_add = 1'b0; add_first = 1'b0; t = '0;
    set_busy = 1'b0; clr_busy = 1'b0; retag = 1'b0;
    set_valid = 1'b0; valid_val = 1'b0; set_dirty = 1'b0; clr_dirty = 1'b0;
    res_c = '{status: bbcm_pkg::ST_ACK, granted_index: '0,
              data_valid: 1'b0, wake_class: bbcm_pkg::WAKE_NONE};
    if (req_r.mode == bbcm_pkg::MODE_GET) begin
      if (hit_r) begin
        t = hit_idx_r;
        if (busy_r[t]) begin
          res_c.status = bbcm_pkg::ST_BUSY;
        end else begin
          set_busy = 1'b1; do_rm = 1'b1;
          res_c.status        = bbcm_pkg::ST_GRANTED;
          res_c.granted_index = 5'(t);
          res_c.data_valid    = valid_r[t];
        end
      end else if (empty_r) begin
        res_c.status = bbcm_pkg::ST_NOFREE;
      end else begin
        t = head_r; do_rm = 1'b1;
        res_c.granted_index = 5'(t);
        if (dirty_r[t]) begin
          res_c.status = bbcm_pkg::ST_WRITEBACK;
        end else begin
          set_busy = 1'b1; retag = 1'b1; set_valid = 1'b1; valid_val = 1'b0;
          res_c.status = bbcm_pkg::ST_GRANTED;
        end
      end
    end else if (rng_ok) begin
      t = ridx;
      unique case (req_r.mode)
        bbcm_pkg::MODE_RELEASE: begin
          do_add = 1'b1; add_first = !valid_r[t]; clr_busy = 1'b1;
          res_c.wake_class = bbcm_pkg::WAKE_FREED;
        end
        bbcm_pkg::MODE_IODONE: begin
          clr_dirty = 1'b1; do_add = !busy_r[t]; add_first = req_r.io_error;
          res_c.wake_class = valid_r[t] ? bbcm_pkg::WAKE_READ : bbcm_pkg::WAKE_WRITE;
          set_valid = 1'b1; valid_val = !req_r.io_error;
        end
        default: set_dirty = 1'b1;
      endcase
    end
    t_n  = next_r[t];
    t_p  = prev_r[t];
    tail = prev_r[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    if (cmd.match) begin
      hit_r     <= hit_c;
      hit_idx_r <= hidx_c;
    end
    if (cmd.exec) res_r <= res_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_dev_r[i] <= '0;
        tag_blk_r[i] <= '0;
        next_r[i]    <= BW'((i + 1) % NUM_BUFFERS);
        prev_r[i]    <= BW'((i + NUM_BUFFERS - 1) % NUM_BUFFERS);
      end
      present_r <= '0; busy_r <= '0; valid_r <= '0; dirty_r <= '0;
      inlist_r  <= '1;
      head_r    <= '0;
      empty_r   <= 1'b0;
    end else if (cmd.exec) begin
      if (set_busy)  busy_r[t]  <= 1'b1;
      if (clr_busy)  busy_r[t]  <= 1'b0;
      if (set_valid) valid_r[t] <= valid_val;
      if (set_dirty) dirty_r[t] <= 1'b1;
      if (clr_dirty) dirty_r[t] <= 1'b0;
      if (retag) begin
        tag_dev_r[t] <= req_r.device[DW-1:0];
        tag_blk_r[t] <= req_r.block_number[KW-1:0];
        present_r[t] <= 1'b1;
      end
      if (do_rm && inlist_r[t]) begin
        inlist_r[t] <= 1'b0;
        if (t_n == t) begin
          empty_r <= 1'b1;
        end else begin
          if (head_r == t) head_r <= t_n;
          prev_r[t_n] <= t_p;
          next_r[t_p] <= t_n;
        end
      end
      if (do_add && !inlist_r[t]) begin
        inlist_r[t] <= 1'b1;
        if (!empty_r) begin
          next_r[t]      <= head_r;
          prev_r[t]      <= tail;
          next_r[tail]   <= t;
          prev_r[head_r] <= t;
          if (add_first) head_r <= t;
        end else begin
          head_r    <= t;
          next_r[t] <= t;
          prev_r[t] <= t;
          empty_r   <= 1'b0;
        end
      end
    end
  end

endmodule

@@ dv/block_buffer_cache_manager_checker.sv @@
// Checker: predicts the buffer cache results and compares them against the out channel.
`timescale 1ns / 100ps
module block_buffer_cache_manager_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bbcm_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bbcm_pkg::out_beat_t out_data,
  output int                  fail_count,
  output int                  pending_count
);
  localparam int NBUF = 32;

  logic [15:0] dev_tag [NBUF];
  logic [31:0] blk_tag [NBUF];
  logic        has_tag [NBUF];
  logic        busy [NBUF];
  logic        valid_data [NBUF];
  logic        dirty [NBUF];
  logic        listed [NBUF];
  logic [4:0]  nxt [NBUF];
  logic [4:0]  prv [NBUF];
  logic [4:0]  head;
  logic        list_empty;

  bbcm_pkg::out_beat_t awaited_results [$];

  function automatic void unlink(int b);
    if (!listed[b]) return;
    if (nxt[b] == b[4:0]) begin
      list_empty = 1'b1;
    end else begin
      if (head == b[4:0]) head = nxt[b];
      prv[nxt[b]] = prv[b];
      nxt[prv[b]] = nxt[b];
    end
    listed[b] = 1'b0;
  endfunction

  function automatic void link(int b, logic at_head);
    logic [4:0] tl;
    if (listed[b]) return;
    if (!list_empty) begin
      tl = prv[head];
      nxt[b] = head;
      prv[b] = tl;
      nxt[tl] = b[4:0];
      prv[head] = b[4:0];
      if (at_head) head = b[4:0];
    end else begin
      head = b[4:0];
      nxt[b] = b[4:0];
      prv[b] = b[4:0];
      list_empty = 1'b0;
    end
    listed[b] = 1'b1;
  endfunction

  function automatic void clear_cache();
    for (int i = 0; i < NBUF; i++) begin
      dev_tag[i] = '0; blk_tag[i] = '0; has_tag[i] = 0; busy[i] = 0;
      valid_data[i] = 0; dirty[i] = 0; listed[i] = 1;
      nxt[i] = 5'((i + 1) % NBUF);
      prv[i] = 5'((i + NBUF - 1) % NBUF);
    end
    head = '0;
    list_empty = 0;
  endfunction

  function automatic bbcm_pkg::out_beat_t cache_response(bbcm_pkg::in_beat_t req);
    bbcm_pkg::out_beat_t r;
    int b;
    logic hit;
    r = '0;
    r.status = bbcm_pkg::ST_ACK;
    r.wake_class = bbcm_pkg::WAKE_NONE;
    hit = 0;
    b = 0;
    if (req.mode == bbcm_pkg::MODE_GET) begin
      for (int i = 0; i < NBUF; i++)
        if (!hit && has_tag[i] && dev_tag[i] == req.device
            && blk_tag[i] == req.block_number) begin
          hit = 1; b = i;
        end
      if (hit) begin
        if (busy[b]) begin
          r.status = bbcm_pkg::ST_BUSY;
        end else begin
          busy[b] = 1;
          unlink(b);
          r.status = bbcm_pkg::ST_GRANTED;
          r.granted_index = b[4:0];
          r.data_valid = valid_data[b];
        end
      end else if (list_empty) begin
        r.status = bbcm_pkg::ST_NOFREE;
      end else begin
        b = int'(head);
        unlink(b);
        r.granted_index = b[4:0];
        if (dirty[b]) begin
          r.status = bbcm_pkg::ST_WRITEBACK;
        end else begin
          busy[b] = 1; valid_data[b] = 0; has_tag[b] = 1;
          dev_tag[b] = req.device; blk_tag[b] = req.block_number;
          r.status = bbcm_pkg::ST_GRANTED;
        end
      end
    end else begin
      b = int'(req.buffer_index);
      case (req.mode)
        bbcm_pkg::MODE_RELEASE: begin
          link(b, !valid_data[b]);
          busy[b] = 0;
          r.wake_class = bbcm_pkg::WAKE_FREED;
        end
        bbcm_pkg::MODE_IODONE: begin
          dirty[b] = 0;
          if (!busy[b]) link(b, req.io_error);
          r.wake_class = valid_data[b] ? bbcm_pkg::WAKE_READ : bbcm_pkg::WAKE_WRITE;
          valid_data[b] = !req.io_error;
        end
        default: dirty[b] = 1;
      endcase
    end
    return r;
  endfunction

  assign pending_count = awaited_results.size();

  always @(posedge clk) begin
    bbcm_pkg::out_beat_t exp_r;
    if (!rst_n) begin
      clear_cache();
      awaited_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = awaited_results.pop_front();
          if (exp_r !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(cache_response(in_data));
    end
  end
endmodule

@@ dv/block_buffer_cache_manager_tb.sv @@
// Testbench top: stimulus, clock, reset and verdict for the buffer cache manager.
`timescale 1ns / 100ps
module block_buffer_cache_manager_tb;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_ready;
  bbcm_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 0;
  bbcm_pkg::out_beat_t out_data;
  int                  fail_count;
  int                  pending_count;
  bit                  calm = 0;      // last stretch: no idling on either side
  bit                  hold_off = 0;  // receiver long stall request

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  block_buffer_cache_manager dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  block_buffer_cache_manager_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .fail_count, .pending_count
  );

  // Small working set of tags so gets hit, miss and collide often.
  logic [15:0] dev_pool [4] = '{16'h0000, 16'hffff, 16'h1234, 16'h8001};
  logic [31:0] blk_pool [4] = '{32'h0, 32'hffff_ffff, 32'h0000_0007, 32'h8000_0000};

  // Send one beat; valid stays up until accepted, then maybe a burst gap.
  task automatic send_beat(bbcm_pkg::in_beat_t b);
    int gap;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic bbcm_pkg::in_beat_t rand_beat();
    bbcm_pkg::in_beat_t b;
    b.mode         = bbcm_pkg::mode_t'($urandom_range(0, 3));
    b.io_error     = ($urandom_range(0, 5) == 0);
    b.buffer_index = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 7) == 0) begin
      b.device       = 16'($urandom);
      b.block_number = $urandom;
    end else begin
      b.device       = dev_pool[$urandom_range(0, 3)];
      b.block_number = blk_pool[$urandom_range(0, 3)] ^ 32'($urandom_range(0, 15));
    end
    return b;
  endfunction

  function automatic bbcm_pkg::in_beat_t mk(bbcm_pkg::mode_t m, logic [15:0] d,
                                            logic [31:0] n, logic [4:0] i, logic e);
    bbcm_pkg::in_beat_t b;
    b.mode = m; b.device = d; b.block_number = n; b.buffer_index = i; b.io_error = e;
    return b;
  endfunction

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 13);
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    int drain;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme tags, hits, busy hit, dirty write-back, errors, list drain.
    send_beat(mk(bbcm_pkg::MODE_GET, 16'hffff, 32'hffff_ffff, 5'd0, 1'b0));
    send_beat(mk(bbcm_pkg::MODE_GET, 16'hffff, 32'hffff_ffff, 5'd0, 1'b0));  // busy retry
    send_beat(mk(bbcm_pkg::MODE_GET, 16'h0000, 32'h0, 5'd0, 1'b0));
    send_beat(mk(bbcm_pkg::MODE_IODONE, 16'h0, 32'h0, 5'd0, 1'b0));   // done on invalid
    send_beat(mk(bbcm_pkg::MODE_DELWRI, 16'h0, 32'h0, 5'd1, 1'b0));
    send_beat(mk(bbcm_pkg::MODE_RELEASE, 16'h0, 32'h0, 5'd0, 1'b0));  // valid -> tail
    send_beat(mk(bbcm_pkg::MODE_RELEASE, 16'h0, 32'h0, 5'd1, 1'b0));  // invalid -> head
    send_beat(mk(bbcm_pkg::MODE_GET, 16'hffff, 32'hffff_ffff, 5'd0, 1'b0));  // hit, valid
    send_beat(mk(bbcm_pkg::MODE_GET, 16'h5555, 32'haaaa_aaaa, 5'd0, 1'b0));  // write-back
    send_beat(mk(bbcm_pkg::MODE_IODONE, 16'h0, 32'h0, 5'd1, 1'b1));   // error: at head
    send_beat(mk(bbcm_pkg::MODE_RELEASE, 16'h0, 32'h0, 5'd31, 1'b1)); // already listed
    send_beat(mk(bbcm_pkg::MODE_DELWRI, 16'h0, 32'h0, 5'd31, 1'b1));
    for (int i = 0; i < 33; i++)                                      // empty the free list
      send_beat(mk(bbcm_pkg::MODE_GET, 16'h00aa, 32'(i), 5'd0, 1'b0));

    // Random: pressure phase first, then mixed traffic, then calm tail.
    hold_off = 1;
    for (int k = 0; k < 750; k++) begin
      if (k == 650) calm = 1;
      send_beat(rand_beat());
    end
    in_valid <= 1'b0;

    drain = 0;
    while (pending_count != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end
endmodule

@@ files.f @@
sv/bbcm_pkg.sv
sv/bbcm_ctrl.sv
sv/bbcm_dp.sv
sv/block_buffer_cache_manager.sv
dv/block_buffer_cache_manager_checker.sv
dv/block_buffer_cache_manager_tb.sv
